// File: rtl/core/rqp_pkg.sv
// Shared types and constants of the ring queue with palindrome check.
package rqp_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned ActionW      = 2;
  localparam int unsigned FillW        = 4;
  localparam int unsigned CmdDepth     = 2;

  localparam logic [ActionW-1:0] ActEnqueue = 2'd0;
  localparam logic [ActionW-1:0] ActDequeue = 2'd1;
  localparam logic [ActionW-1:0] ActPeek    = 2'd2;
  localparam logic [ActionW-1:0] ActCheck   = 2'd3;

  typedef enum logic [1:0] {
    OpEnq,
    OpDeq,
    OpPeek,
    OpCheck
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] front_value;
    logic             full_error;
    logic             empty_error;
    logic             is_palindrome;
    logic [FillW-1:0] fill_count;
  } res_t;

endpackage

// File: rtl/core/rqp_in_if.sv
// Input channel of the ring queue: one action word with its byte.
interface rqp_in_if import rqp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [ByteW-1:0]   data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// File: rtl/core/rqp_out_if.sv
// Result channel of the ring queue: one result word per action.
interface rqp_out_if import rqp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] front_value;
  logic             full_error;
  logic             empty_error;
  logic             is_palindrome;
  logic [FillW-1:0] fill_count;

  modport source (output valid, output front_value, output full_error, output empty_error,
                  output is_palindrome, output fill_count, input ready);
  modport sink   (input valid, input front_value, input full_error, input empty_error,
                  input is_palindrome, input fill_count, output ready);
endinterface

// File: rtl/core/rqp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rqp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rqp_front.sv
// Front end: accepts action words, decodes them and queues the commands.
module rqp_front import rqp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [ActionW-1:0] action_i,
  input  logic [ByteW-1:0]   data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output cmd_t               cmd_o
);

  localparam int unsigned PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdDepth + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CmdDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CmdDepth - 1);

  cmd_t            entry_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  cmd_t            dec_cmd;
  logic            push, pop;

  always_comb begin
    dec_cmd.data = data_i;
    case (action_i)
      ActEnqueue: dec_cmd.op = OpEnq;
      ActDequeue: dec_cmd.op = OpDeq;
      ActPeek:    dec_cmd.op = OpPeek;
      default:    dec_cmd.op = OpCheck;
    endcase
  end

  assign ready_o     = (cnt_q != FullCnt);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = valid_i && ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

// File: rtl/core/rqp_engine.sv
// Back end: holds the ring, carries out commands and registers the result word.
module rqp_engine import rqp_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  typedef enum logic [1:0] {
    StIdle,
    StPeek,
    StCheck
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [IdxW-1:0] count_q, count_d;
  logic [IdxW-1:0] a_q, a_d;
  logic [IdxW-1:0] b_q, b_d;
  logic [IdxW-1:0] k_q, k_d;
  logic            pend_q, pend_d;
  logic            same_q, same_d;
  logic            out_valid_q, out_valid_d;
  res_t            res_q, res_d;

  logic             wr_en;
  logic             out_free;
  logic             emit;
  res_t             res_n;
  logic [IdxW-1:0]  rd_addr_a;
  logic [ByteW-1:0] rd_data_a, rd_data_b;
  logic [IdxW+FillW-1:0] fill_wide;

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] ring_prev(input logic [IdxW-1:0] idx);
    return (idx == '0) ? LastIdx : idx - 1'b1;
  endfunction

  assign rd_addr_a = (state_q == StCheck) ? a_q : head_q;

  rqp_ram #(.Width(ByteW), .Depth(SLOTS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail_q),
    .wdata_i (cmd_i.data),
    .raddr_i (rd_addr_a),
    .rdata_o (rd_data_a)
  );

  rqp_ram #(.Width(ByteW), .Depth(SLOTS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail_q),
    .wdata_i (cmd_i.data),
    .raddr_i (b_q),
    .rdata_o (rd_data_b)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    pend_d      = pend_q;
    same_d      = same_q;
    res_d       = res_q;
    out_free    = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;
    wr_en       = 1'b0;
    cmd_ready_o = 1'b0;
    emit        = 1'b0;
    res_n       = '0;

    case (state_q)
      StIdle: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          case (cmd_i.op)
            OpEnq: begin
              emit = 1'b1;
              if (count_q == LastIdx) begin
                res_n.full_error = 1'b1;
              end else begin
                wr_en   = 1'b1;
                tail_d  = ring_next(tail_q);
                count_d = count_q + 1'b1;
              end
            end
            OpDeq: begin
              emit = 1'b1;
              if (count_q == '0) begin
                res_n.empty_error = 1'b1;
              end else begin
                head_d  = ring_next(head_q);
                count_d = count_q - 1'b1;
              end
            end
            OpPeek: begin
              if (count_q == '0) begin
                emit              = 1'b1;
                res_n.empty_error = 1'b1;
              end else begin
                state_d = StPeek;
              end
            end
            default: begin
              a_d     = head_q;
              b_d     = ring_prev(tail_q);
              k_d     = count_q >> 1;
              pend_d  = 1'b0;
              same_d  = 1'b1;
              state_d = StCheck;
            end
          endcase
        end
      end
      StPeek: begin
        if (out_free) begin
          emit              = 1'b1;
          res_n.front_value = rd_data_a;
          state_d           = StIdle;
        end
      end
      StCheck: begin
        if (pend_q && (rd_data_a != rd_data_b)) begin
          same_d = 1'b0;
        end
        if (k_q != '0) begin
          a_d    = ring_next(a_q);
          b_d    = ring_prev(b_q);
          k_d    = k_q - 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q && out_free) begin
            emit                = 1'b1;
            res_n.is_palindrome = same_q;
            state_d             = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    fill_wide = {{FillW{1'b0}}, count_d};
    if (emit) begin
      out_valid_d      = 1'b1;
      res_d            = res_n;
      res_d.fill_count = fill_wide[FillW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      a_q         <= '0;
      b_q         <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      same_q      <= 1'b1;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      a_q         <= a_d;
      b_q         <= b_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      same_q      <= same_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/core/ring_queue_palindrome_check.sv
// Circular byte queue of SLOTS entries (one kept free) with a palindrome check.
//
// Each word on in_i carries an action (enqueue, dequeue, peek, check) and a byte;
// each accepted word yields exactly one result word on out_o, in order.
// A two-entry command queue at the front takes words while the back end works
// or while a result waits, so the sender sees back pressure only when it fills.
// Enqueue and dequeue finish in the idle state of the back end; a peek goes
// through its own state, as the ring RAM has a registered read port. The check
// walks mirrored pairs, one pair per cycle over two RAM read ports, and the
// result word of every action is registered in the back end. When the receiver
// stalls, the result word is held unchanged and the back end waits; the front
// queue keeps taking words until it is full.
// Reset empties the ring (head, tail and count go to zero) and drops any queued
// words; ring contents are not cleared and need no clearing pass.
module ring_queue_palindrome_check import rqp_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  rqp_in_if.sink    in_i,
  rqp_out_if.source out_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;

  rqp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .action_i    (in_i.action),
    .data_i      (in_i.data_byte),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  rqp_engine #(.SLOTS(SLOTS)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.front_value   = res.front_value;
  assign out_o.full_error    = res.full_error;
  assign out_o.empty_error   = res.empty_error;
  assign out_o.is_palindrome = res.is_palindrome;
  assign out_o.fill_count    = res.fill_count;

endmodule

// File: rtl/core/rqp_checker.sv
// Port-level checks of the ring queue result channel, bound to the top level.
module rqp_checker import rqp_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] front_value_i,
  input logic             full_error_i,
  input logic             empty_error_i,
  input logic             is_palindrome_i,
  input logic [FillW-1:0] fill_count_i
);

  localparam logic [FillW-1:0] FullFill = FillW'(SLOTS - 1);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result word dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(front_value_i) && $stable(fill_count_i))
    else $error("Result word changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && full_error_i |-> fill_count_i == FullFill && !empty_error_i)
    else $error("Full error reported with a queue that is not full.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_error_i |-> fill_count_i == '0 && front_value_i == '0)
    else $error("Empty error reported with bytes held or a front value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_palindrome_i |-> !full_error_i && !empty_error_i && front_value_i == '0)
    else $error("Palindrome flag set together with another result.");

endmodule

bind ring_queue_palindrome_check rqp_checker #(.SLOTS(SLOTS)) u_rqp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .front_value_i   (out_o.front_value),
  .full_error_i    (out_o.full_error),
  .empty_error_i   (out_o.empty_error),
  .is_palindrome_i (out_o.is_palindrome),
  .fill_count_i    (out_o.fill_count)
);
